/* hw/rtl/analog_clock_sync_controller_defines.svh */
// ============================================================================
// analog_clock_sync_controller_defines.svh
// Assertion macros shared by the clock sync controller RTL.
// ============================================================================
`ifndef ANALOG_CLOCK_SYNC_CONTROLLER_DEFINES_SVH
`define ANALOG_CLOCK_SYNC_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define ACSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define ACSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/acsc_pkg.sv */
// ============================================================================
// acsc_pkg
// Types and constants of the analog clock sync controller.
// ============================================================================
package acsc_pkg;

    // Item kinds
    localparam logic [2:0] KIND_MSG     = 3'd0;
    localparam logic [2:0] KIND_TICK    = 3'd1;
    localparam logic [2:0] KIND_WDOG    = 3'd2;
    localparam logic [2:0] KIND_SYNC    = 3'd3;
    localparam logic [2:0] KIND_RESTORE = 3'd4;

    // Bus commands
    localparam logic [7:0] OP_START     = 8'h02;
    localparam logic [7:0] OP_STOP      = 8'h04;
    localparam logic [7:0] OP_SET_CLOCK = 8'h06;
    localparam logic [7:0] OP_SET_NET   = 8'h08;

    // Step actions
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_PULSE   = 2'd1;
    localparam logic [1:0] ACT_ADVANCE = 2'd2;

    localparam logic [7:0] CSUM_SEED      = 8'hCC;
    localparam logic [7:0] PIN_COIL0      = 8'd3;
    localparam logic [7:0] PIN_COIL1      = 8'd4;
    localparam logic [7:0] LAST_SEC_INIT  = 8'd255;
    localparam logic [7:0] SEC_PER_MIN    = 8'd60;
    localparam logic [7:0] MIN_PER_HOUR   = 8'd60;
    localparam logic [7:0] HOURS_PER_DIAL = 8'd12;
    localparam logic [2:0] MSG_LEN_MAX    = 3'd5;

    // Seconds arithmetic: 255 h * 3600 fits in 20 bits, signed diff in 22
    localparam int SECS_W = 20;
    localparam int DIFF_W = 22;
    localparam logic [SECS_W-1:0] SECS_PER_HOUR = 20'd3600;
    localparam logic [SECS_W-1:0] SECS_PER_MIN  = 20'd60;
    localparam logic signed [DIFF_W-1:0] HALF_DAY   = 22'sd43200;
    localparam logic signed [DIFF_W-1:0] NEAR_AHEAD = 22'sd300;

    typedef struct packed {
        logic [7:0] hours;
        logic [7:0] minutes;
        logic [7:0] seconds;
    } acsc_time_t;

    typedef struct packed {
        logic [2:0]      kind;
        logic [2:0]      msg_len;
        logic [4:0][7:0] bytes;
    } acsc_item_t;

    // Message bytes 1..3 are the only buffered bytes a command reads back
    typedef struct packed {
        acsc_time_t      clk_time;
        acsc_time_t      net_time;
        logic            run;
        logic            next_coil;
        logic [7:0]      last_net_sec;
        logic [2:0][7:0] msg_buf;
    } acsc_state_t;

    typedef struct packed {
        logic [1:0] action;
        logic       coil;
        acsc_time_t clk_time;
        logic       running;
        logic       save_request;
        logic [7:0] save_checksum;
        logic       accepted;
    } acsc_result_t;

    localparam acsc_state_t STATE_INIT = '{
        clk_time:     '0,
        net_time:     '0,
        run:          1'b0,
        next_coil:    1'b0,
        last_net_sec: LAST_SEC_INIT,
        msg_buf:      '0
    };

endpackage

/* hw/rtl/acsc_step.sv */
// ============================================================================
// acsc_step
// Single-pass next-state and result logic for one registered item.
// ============================================================================
module acsc_step
(
    input  acsc_pkg::acsc_item_t   item,
    input  acsc_pkg::acsc_state_t  cur,
    output acsc_pkg::acsc_state_t  nxt,
    output acsc_pkg::acsc_result_t res
);

    logic [7:0]                           msg_sum;
    logic [7:0]                           msg_chk;
    logic                                 msg_len_ok;
    logic                                 msg_ok;
    logic [7:0]                           rst_sum;
    logic [7:0]                           stop_sum;
    logic [acsc_pkg::SECS_W-1:0]          clk_secs;
    logic [acsc_pkg::SECS_W-1:0]          net_secs;
    logic signed [acsc_pkg::DIFF_W-1:0]   diff;
    logic signed [acsc_pkg::DIFF_W-1:0]   diff_adj;
    acsc_pkg::acsc_time_t                 msg_time;

    // Advance a 12-hour time by one second; a field at 255 wraps without carry
    function automatic acsc_pkg::acsc_time_t time_inc(input acsc_pkg::acsc_time_t t);
        acsc_pkg::acsc_time_t r;
        r = t;
        r.seconds = t.seconds + 8'd1;
        if (r.seconds >= acsc_pkg::SEC_PER_MIN)
        begin
            r.seconds = 8'd0;
            r.minutes = t.minutes + 8'd1;
            if (r.minutes >= acsc_pkg::MIN_PER_HOUR)
            begin
                r.minutes = 8'd0;
                r.hours   = t.hours + 8'd1;
                if (r.hours >= acsc_pkg::HOURS_PER_DIAL)
                begin
                    r.hours = 8'd0;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [acsc_pkg::SECS_W-1:0] secs_of(input acsc_pkg::acsc_time_t t);
        return acsc_pkg::SECS_W'(t.hours) * acsc_pkg::SECS_PER_HOUR
             + acsc_pkg::SECS_W'(t.minutes) * acsc_pkg::SECS_PER_MIN
             + acsc_pkg::SECS_W'(t.seconds);
    endfunction

    // Signed distance clock minus network, folded into the half day once
    assign clk_secs = secs_of(cur.clk_time);
    assign net_secs = secs_of(cur.net_time);
    assign diff     = $signed({2'b00, clk_secs}) - $signed({2'b00, net_secs});
    assign diff_adj = (diff < 0) ? diff + acsc_pkg::HALF_DAY : diff;

    // Snapshot the persisted state for a stop
    assign stop_sum = acsc_pkg::CSUM_SEED ^ cur.clk_time.hours ^ cur.clk_time.minutes
                    ^ cur.clk_time.seconds
                    ^ (cur.next_coil ? acsc_pkg::PIN_COIL1 : acsc_pkg::PIN_COIL0);

    assign rst_sum = acsc_pkg::CSUM_SEED ^ item.bytes[0] ^ item.bytes[1]
                   ^ item.bytes[2] ^ item.bytes[3];

    // Check the message: CSUM_SEED XOR all bytes but the last, against the last
    assign msg_len_ok = (item.msg_len != 3'd0) && (item.msg_len <= acsc_pkg::MSG_LEN_MAX);

    always_comb
    begin
        case (item.msg_len)
            3'd2:
            begin
                msg_sum = acsc_pkg::CSUM_SEED ^ item.bytes[0];
                msg_chk = item.bytes[1];
            end
            3'd3:
            begin
                msg_sum = acsc_pkg::CSUM_SEED ^ item.bytes[0] ^ item.bytes[1];
                msg_chk = item.bytes[2];
            end
            3'd4:
            begin
                msg_sum = acsc_pkg::CSUM_SEED ^ item.bytes[0] ^ item.bytes[1]
                        ^ item.bytes[2];
                msg_chk = item.bytes[3];
            end
            3'd5:
            begin
                msg_sum = rst_sum;
                msg_chk = item.bytes[4];
            end
            default:
            begin
                msg_sum = acsc_pkg::CSUM_SEED;
                msg_chk = item.bytes[0];
            end
        endcase
    end

    assign msg_ok = msg_len_ok && (msg_sum == msg_chk);

    // Update state and build the result
    always_comb
    begin
        nxt                = cur;
        res.action         = acsc_pkg::ACT_NONE;
        res.save_request   = 1'b0;
        res.save_checksum  = 8'd0;
        res.accepted       = 1'b0;
        msg_time           = '0;

        case (item.kind)
            acsc_pkg::KIND_MSG:
            begin
                if (msg_len_ok)
                begin
                    // Overwrite only the bytes carried by this message
                    if (item.msg_len > 3'd1) nxt.msg_buf[0] = item.bytes[1];
                    if (item.msg_len > 3'd2) nxt.msg_buf[1] = item.bytes[2];
                    if (item.msg_len > 3'd3) nxt.msg_buf[2] = item.bytes[3];
                end
                msg_time.hours   = nxt.msg_buf[0];
                msg_time.minutes = nxt.msg_buf[1];
                msg_time.seconds = nxt.msg_buf[2];
                if (msg_ok)
                begin
                    res.accepted = 1'b1;
                    case (item.bytes[0])
                        acsc_pkg::OP_START:
                        begin
                            nxt.run          = 1'b1;
                            nxt.last_net_sec = acsc_pkg::LAST_SEC_INIT;
                        end
                        acsc_pkg::OP_STOP:
                        begin
                            nxt.run           = 1'b0;
                            res.save_request  = 1'b1;
                            res.save_checksum = stop_sum;
                        end
                        acsc_pkg::OP_SET_CLOCK:
                        begin
                            nxt.clk_time = msg_time;
                            nxt.net_time = msg_time;
                        end
                        acsc_pkg::OP_SET_NET:
                        begin
                            nxt.net_time = msg_time;
                        end
                        default:
                        begin
                            nxt.run = cur.run;
                        end
                    endcase
                end
            end
            acsc_pkg::KIND_TICK:
            begin
                if (cur.run)
                begin
                    nxt.net_time = time_inc(cur.net_time);
                end
            end
            acsc_pkg::KIND_WDOG:
            begin
                // Stop when network seconds stalled since the last check
                if (cur.run && (cur.last_net_sec == cur.net_time.seconds))
                begin
                    nxt.run           = 1'b0;
                    res.save_request  = 1'b1;
                    res.save_checksum = stop_sum;
                end
                nxt.last_net_sec = cur.net_time.seconds;
            end
            acsc_pkg::KIND_SYNC:
            begin
                if (cur.run && (diff != 0))
                begin
                    if (diff_adj <= acsc_pkg::NEAR_AHEAD)
                    begin
                        res.action = acsc_pkg::ACT_PULSE;
                    end
                    else
                    begin
                        res.action    = acsc_pkg::ACT_ADVANCE;
                        nxt.clk_time  = time_inc(cur.clk_time);
                        nxt.next_coil = ~cur.next_coil;
                    end
                end
            end
            acsc_pkg::KIND_RESTORE:
            begin
                if (rst_sum == item.bytes[4])
                begin
                    res.accepted          = 1'b1;
                    nxt.clk_time.hours    = item.bytes[0];
                    nxt.clk_time.minutes  = item.bytes[1];
                    nxt.clk_time.seconds  = item.bytes[2];
                    nxt.net_time          = nxt.clk_time;
                    nxt.next_coil         = (item.bytes[3] == acsc_pkg::PIN_COIL1);
                end
                else
                begin
                    nxt.clk_time  = '0;
                    nxt.net_time  = '0;
                    nxt.next_coil = 1'b0;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase

        res.coil     = (item.kind == acsc_pkg::KIND_RESTORE) ? nxt.next_coil : cur.next_coil;
        res.clk_time = nxt.clk_time;
        res.running  = nxt.run;
    end

endmodule

/* hw/rtl/analog_clock_sync_controller.sv */
// ============================================================================
// analog_clock_sync_controller
// Keeps a two-coil analog movement in step with a 1 Hz network time.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) carries one event: a bus message, a
//   second tick, a watchdog check, a sync step or a saved-record restore.
//   Output channel (out_valid/out_ready) returns exactly one status item per
//   event: coil action, coil, clock time, run flag, save request and
//   checksum, and whether a message or record passed its checksum.
//   Path: a transferred event sits in the input register, is evaluated in
//   a single combinational pass against the state registers and lands in
//   the output register once that register is free or being emptied.
//   Throughput: one event per cycle while out_ready is high; the state
//   update for an event is done in the same cycle it moves to the output
//   register, so the next event sees it at once.
//   Reset: both times 00:00:00, clock stopped, first coil next, watchdog
//   reference at 255, message buffer cleared, both stages empty.
//   Stall: while out_ready is low the output register holds; one more event
//   may wait in the input register, then in_ready drops.
// ============================================================================
`include "analog_clock_sync_controller_defines.svh"

module analog_clock_sync_controller
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] kind,
    input  logic [2:0] msg_len,
    input  logic [7:0] byte0,
    input  logic [7:0] byte1,
    input  logic [7:0] byte2,
    input  logic [7:0] byte3,
    input  logic [7:0] byte4,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] action,
    output logic       coil,
    output logic [7:0] clock_hours,
    output logic [7:0] clock_minutes,
    output logic [7:0] clock_seconds,
    output logic       running,
    output logic       save_request,
    output logic [7:0] save_checksum,
    output logic       message_accepted
);

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    acsc_pkg::acsc_item_t   s1_item_reg;
    acsc_pkg::acsc_item_t   in_item;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    acsc_pkg::acsc_result_t res_reg;
    acsc_pkg::acsc_result_t step_res;
    acsc_pkg::acsc_state_t  state_reg;
    acsc_pkg::acsc_state_t  state_next;
    acsc_pkg::acsc_state_t  step_state;
    logic                   in_fire;
    logic                   s1_go;
    logic                   s1_fire;

    // Pack the input fields
    always_comb
    begin
        in_item.kind     = kind;
        in_item.msg_len  = msg_len;
        in_item.bytes[0] = byte0;
        in_item.bytes[1] = byte1;
        in_item.bytes[2] = byte2;
        in_item.bytes[3] = byte3;
        in_item.bytes[4] = byte4;
    end

    // Handshake: the input stage moves on whenever the output register frees
    assign s1_go    = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && s1_go;
    assign in_ready = !s1_valid_reg || s1_go;
    assign in_fire  = in_valid && in_ready;

    acsc_step u_step
    (
        .item (s1_item_reg),
        .cur  (state_reg),
        .nxt  (step_state),
        .res  (step_res)
    );

    // Compute next control and state values
    always_comb
    begin
        s1_valid_next  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        state_next     = s1_fire ? step_state : state_reg;
    end

    // Hold control and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= acsc_pkg::STATE_INIT;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_fire)
        begin
            res_reg <= step_res;
        end
    end

    // Drive the result ports
    assign out_valid        = out_valid_reg;
    assign action           = res_reg.action;
    assign coil             = res_reg.coil;
    assign clock_hours      = res_reg.clk_time.hours;
    assign clock_minutes    = res_reg.clk_time.minutes;
    assign clock_seconds    = res_reg.clk_time.seconds;
    assign running          = res_reg.running;
    assign save_request     = res_reg.save_request;
    assign save_checksum    = res_reg.save_checksum;
    assign message_accepted = res_reg.accepted;

    // A stop always leaves the clock stopped
    `ACSC_ASSERT_NOW(a_stop_clears_run,
        s1_fire && step_res.save_request,
        !step_state.run,
        "save request with clock still running")

    // Coil actions only happen while running
    `ACSC_ASSERT_NOW(a_action_needs_run,
        s1_fire && (step_res.action != acsc_pkg::ACT_NONE),
        state_reg.run && (s1_item_reg.kind == acsc_pkg::KIND_SYNC),
        "coil action outside a running sync step")

    // An advancing step flips the coil for the next one
    `ACSC_ASSERT_NEXT(a_advance_flips_coil,
        s1_fire && (step_res.action == acsc_pkg::ACT_ADVANCE),
        state_reg.next_coil != $past(state_reg.next_coil),
        "advance did not alternate coils")

    // State changes only when an item leaves the input stage
    `ACSC_ASSERT_NEXT(a_state_holds,
        !s1_fire,
        $stable(state_reg),
        "state changed without an item")

endmodule
